### design/msr_pkg.sv
// Shared types and constants for the modular square root block.
// No dependencies; imported by every module of the block.
package msr_pkg;
  localparam int MOD_WIDTH = 32;
  localparam int VAL_WIDTH = MOD_WIDTH + 1;
  localparam int MUL_STEPS = VAL_WIDTH;
  localparam int CNT_WIDTH = $clog2(MUL_STEPS + 1);
  localparam int SH_WIDTH  = $clog2(MOD_WIDTH) + 1;

  localparam logic [1:0] SYM_ZERO    = 2'd0;
  localparam logic [1:0] SYM_RESIDUE = 2'd1;
  localparam logic [1:0] SYM_NONRES  = 2'd2;

  typedef enum logic [20:0] {
    ST_IDLE     = 21'h000001,
    ST_RED      = 21'h000002,
    ST_PW_CHECK = 21'h000004,
    ST_PW_WACC  = 21'h000008,
    ST_PW_WSQ   = 21'h000010,
    ST_CLASS    = 21'h000020,
    ST_ROOT_FIN = 21'h000040,
    ST_FACT     = 21'h000080,
    ST_ZCHK     = 21'h000100,
    ST_ZCLS     = 21'h000200,
    ST_GOT_C    = 21'h000400,
    ST_GOT_T    = 21'h000800,
    ST_GOT_R    = 21'h001000,
    ST_TLOOP    = 21'h002000,
    ST_SQCHK    = 21'h004000,
    ST_SQW      = 21'h008000,
    ST_GOT_B    = 21'h010000,
    ST_WC       = 21'h020000,
    ST_WT       = 21'h040000,
    ST_WR       = 21'h080000,
    ST_FIN      = 21'h100000
  } state_t;

  typedef struct packed {
    logic                 go;
    logic [VAL_WIDTH-1:0] x;
    logic [MOD_WIDTH-1:0] y;
  } mul_req_t;
endpackage

### design/msr_mulm.sv
// Bit-serial modular multiplier: x * y mod p, one bit of x per cycle.
// Depends on msr_pkg.
module msr_mulm (
  input  logic                         clk,
  input  logic                         rst,
  input  msr_pkg::mul_req_t            req,
  input  logic [msr_pkg::MOD_WIDTH-1:0] p,
  output logic                         done,
  output logic [msr_pkg::MOD_WIDTH-1:0] product
);
  import msr_pkg::*;

  logic                 busy;
  logic [CNT_WIDTH-1:0] cnt;
  logic [VAL_WIDTH-1:0] xs;
  logic [MOD_WIDTH-1:0] yv;
  logic [MOD_WIDTH-1:0] acc;
  logic [VAL_WIDTH-1:0] dbl, red1, sum, res, pw;

  always_comb begin
    pw   = {1'b0, p};
    dbl  = {acc, 1'b0};
    red1 = (dbl >= pw) ? dbl - pw : dbl;
    sum  = red1 + (xs[VAL_WIDTH-1] ? {1'b0, yv} : '0);
    res  = (sum >= pw) ? sum - pw : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy && req.go) begin
        xs   <= req.x;
        yv   <= req.y;
        acc  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        acc <= res[MOD_WIDTH-1:0];
        xs  <= xs << 1;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_WIDTH'(MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product = acc;
endmodule

### design/msr_ctrl.sv
// Sequencer for reduction, Euler's criterion and Tonelli-Shanks.
// Depends on msr_pkg; drives the shared msr_mulm unit.
module msr_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [msr_pkg::VAL_WIDTH-1:0] value,
  input  logic [msr_pkg::MOD_WIDTH-1:0] p,
  input  logic                          mul_done,
  input  logic [msr_pkg::MOD_WIDTH-1:0] mul_prod,
  output msr_pkg::mul_req_t             mul_req,
  output logic                          busy,
  output logic                          done,
  output logic [1:0]                    symbol,
  output logic [msr_pkg::MOD_WIDTH-1:0] root
);
  import msr_pkg::*;

  state_t               state, pw_ret;
  logic                 neg;
  logic [MOD_WIDTH-1:0] a, q, z, c, t, r, t2, pw_base, pw_exp, pw_acc;
  logic [SH_WIDTH-1:0]  s, m, i, sh;
  logic [VAL_WIDTH-1:0] p_inc;
  logic                 acc_one;

  always_comb begin
    p_inc   = {1'b0, p} + 1'b1;
    sh      = m - i - 1'b1;
    acc_one = (pw_acc == MOD_WIDTH'(1));
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      mul_req.go <= 1'b0;
    end else begin
      done       <= 1'b0;
      mul_req.go <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            if (p < MOD_WIDTH'(3) || !p[0]) begin
              symbol <= SYM_ZERO;
              root   <= '0;
              state  <= ST_FIN;
            end else begin
              neg        <= value[VAL_WIDTH-1];
              mul_req.x  <= value[VAL_WIDTH-1] ? (~value + 1'b1) : value;
              mul_req.y  <= MOD_WIDTH'(1);
              mul_req.go <= 1'b1;
              state      <= ST_RED;
            end
          end
        end
        ST_RED: begin
          if (mul_done) begin
            a       <= (neg && mul_prod != '0) ? p - mul_prod : mul_prod;
            pw_base <= (neg && mul_prod != '0) ? p - mul_prod : mul_prod;
            pw_exp  <= p >> 1;
            pw_acc  <= MOD_WIDTH'(1);
            pw_ret  <= ST_CLASS;
            state   <= ST_PW_CHECK;
          end
        end
        // square-and-multiply, returns to pw_ret with result in pw_acc
        ST_PW_CHECK: begin
          if (pw_exp == '0) begin
            state <= pw_ret;
          end else if (pw_exp[0]) begin
            mul_req.x  <= {1'b0, pw_acc};
            mul_req.y  <= pw_base;
            mul_req.go <= 1'b1;
            state      <= ST_PW_WACC;
          end else begin
            mul_req.x  <= {1'b0, pw_base};
            mul_req.y  <= pw_base;
            mul_req.go <= 1'b1;
            state      <= ST_PW_WSQ;
          end
        end
        ST_PW_WACC: begin
          if (mul_done) begin
            pw_acc     <= mul_prod;
            mul_req.x  <= {1'b0, pw_base};
            mul_req.y  <= pw_base;
            mul_req.go <= 1'b1;
            state      <= ST_PW_WSQ;
          end
        end
        ST_PW_WSQ: begin
          if (mul_done) begin
            pw_base <= mul_prod;
            pw_exp  <= pw_exp >> 1;
            state   <= ST_PW_CHECK;
          end
        end
        ST_CLASS: begin
          root <= '0;
          if (pw_acc == '0) begin
            symbol <= SYM_ZERO;
            state  <= ST_FIN;
          end else if (!acc_one) begin
            symbol <= SYM_NONRES;
            state  <= ST_FIN;
          end else begin
            symbol <= SYM_RESIDUE;
            if (a == '0) begin
              state <= ST_FIN;
            end else if (p[1:0] == 2'b11) begin
              pw_base <= a;
              pw_exp  <= MOD_WIDTH'(p_inc >> 2);
              pw_acc  <= MOD_WIDTH'(1);
              pw_ret  <= ST_ROOT_FIN;
              state   <= ST_PW_CHECK;
            end else begin
              q     <= p - 1'b1;
              s     <= '0;
              state <= ST_FACT;
            end
          end
        end
        ST_ROOT_FIN: begin
          root  <= pw_acc;
          state <= ST_FIN;
        end
        ST_FACT: begin
          if (q != '0 && !q[0]) begin
            q <= q >> 1;
            s <= s + 1'b1;
          end else begin
            z     <= MOD_WIDTH'(2);
            state <= ST_ZCHK;
          end
        end
        // search upward for a non-residue
        ST_ZCHK: begin
          if (z < p) begin
            pw_base <= z;
            pw_exp  <= p >> 1;
            pw_acc  <= MOD_WIDTH'(1);
            pw_ret  <= ST_ZCLS;
            state   <= ST_PW_CHECK;
          end else begin
            root  <= '0;
            state <= ST_FIN;
          end
        end
        ST_ZCLS: begin
          if (pw_acc != '0 && !acc_one) begin
            m       <= s;
            pw_base <= z;
            pw_exp  <= q;
            pw_acc  <= MOD_WIDTH'(1);
            pw_ret  <= ST_GOT_C;
            state   <= ST_PW_CHECK;
          end else begin
            z     <= z + 1'b1;
            state <= ST_ZCHK;
          end
        end
        ST_GOT_C: begin
          c       <= pw_acc;
          pw_base <= a;
          pw_exp  <= q;
          pw_acc  <= MOD_WIDTH'(1);
          pw_ret  <= ST_GOT_T;
          state   <= ST_PW_CHECK;
        end
        ST_GOT_T: begin
          t       <= pw_acc;
          pw_base <= a;
          pw_exp  <= MOD_WIDTH'(({1'b0, q} + 1'b1) >> 1);
          pw_acc  <= MOD_WIDTH'(1);
          pw_ret  <= ST_GOT_R;
          state   <= ST_PW_CHECK;
        end
        ST_GOT_R: begin
          r     <= pw_acc;
          state <= ST_TLOOP;
        end
        ST_TLOOP: begin
          if (t == MOD_WIDTH'(1)) begin
            root  <= r;
            state <= ST_FIN;
          end else begin
            i     <= '0;
            t2    <= t;
            state <= ST_SQCHK;
          end
        end
        ST_SQCHK: begin
          if (t2 != MOD_WIDTH'(1) && i < m) begin
            mul_req.x  <= {1'b0, t2};
            mul_req.y  <= t2;
            mul_req.go <= 1'b1;
            state      <= ST_SQW;
          end else if (t2 != MOD_WIDTH'(1) || i == '0) begin
            root  <= '0;
            state <= ST_FIN;
          end else begin
            pw_base <= c;
            pw_exp  <= MOD_WIDTH'(1) << sh[SH_WIDTH-2:0];
            pw_acc  <= MOD_WIDTH'(1);
            pw_ret  <= ST_GOT_B;
            state   <= ST_PW_CHECK;
          end
        end
        ST_SQW: begin
          if (mul_done) begin
            t2    <= mul_prod;
            i     <= i + 1'b1;
            state <= ST_SQCHK;
          end
        end
        ST_GOT_B: begin
          m          <= i;
          mul_req.x  <= {1'b0, pw_acc};
          mul_req.y  <= pw_acc;
          mul_req.go <= 1'b1;
          state      <= ST_WC;
        end
        ST_WC: begin
          if (mul_done) begin
            c          <= mul_prod;
            mul_req.x  <= {1'b0, t};
            mul_req.y  <= mul_prod;
            mul_req.go <= 1'b1;
            state      <= ST_WT;
          end
        end
        ST_WT: begin
          if (mul_done) begin
            t          <= mul_prod;
            mul_req.x  <= {1'b0, r};
            mul_req.y  <= pw_acc;
            mul_req.go <= 1'b1;
            state      <= ST_WR;
          end
        end
        ST_WR: begin
          if (mul_done) begin
            r     <= mul_prod;
            state <= ST_TLOOP;
          end
        end
        ST_FIN: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

### design/modular_square_root_top.sv
// Top level of the modular square root block: modulus register, sequencer
// and shared multiplier. Depends on msr_pkg, msr_ctrl and msr_mulm.
//
// A request is taken when start is high and busy is low; the result appears
// on symbol and root while done is high for one cycle, and cannot be held off.
// Every modular product goes through one bit-serial multiplier of 33 steps.
// Classification takes one squaring per bit of (p-1)/2 and one further
// product for each set bit; a modulus of 3 mod 4 adds one more such
// power. Otherwise the non-residue search and the Tonelli-Shanks loop add
// one power per candidate tried plus up to s*s squarings. A modulus write
// is taken only while busy and start are both low.
module modular_square_root_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [msr_pkg::VAL_WIDTH-1:0] value,
  output logic                          done,
  output logic [1:0]                    symbol,
  output logic [msr_pkg::MOD_WIDTH-1:0] root,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [31:0]                   cfg_data
);
  import msr_pkg::*;

  logic [MOD_WIDTH-1:0] prime_modulus;
  mul_req_t             mul_req;
  logic                 mul_done;
  logic [MOD_WIDTH-1:0] mul_prod;

  // hold off a write while a request is in flight or being taken
  assign cfg_ready = !busy && !start;

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_modulus <= MOD_WIDTH'(3);
    end else if (cfg_valid && cfg_ready) begin
      prime_modulus <= cfg_data[MOD_WIDTH-1:0];
    end
  end

  msr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .value    (value),
    .p        (prime_modulus),
    .mul_done (mul_done),
    .mul_prod (mul_prod),
    .mul_req  (mul_req),
    .busy     (busy),
    .done     (done),
    .symbol   (symbol),
    .root     (root)
  );

  msr_mulm u_mulm (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .p       (prime_modulus),
    .done    (mul_done),
    .product (mul_prod)
  );
endmodule
